@@ src/ptb_pkg.sv @@
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_W     = 4;
   localparam int RELOAD_W   = 16;
   localparam int PERIOD_W   = 8;
   localparam int REM_W      = RELOAD_W + 1;

   typedef enum logic [2:0] {
      OP_PROGRAM = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_ENABLE  = 3'd3,
      OP_TICK    = 3'd4,
      OP_SERVICE = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERR   = 2'd1,
      ST_FIRED = 2'd2,
      ST_OFF   = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [SLOT_W-1:0]   slot;
      logic [RELOAD_W-1:0] reload_value;
      logic                one_shot;
      logic                urgent;
      logic [PERIOD_W-1:0] tick_period;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] fired_slot;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic pending;
      logic single_fire;
      logic immediate;
   } slot_flags_type;

   typedef struct packed {
      logic             active;
      logic             pending;
      logic             fire;
      logic [REM_W-1:0] remaining;
   } slot_update_type;

endpackage

@@ src/ptb_slot_unit.sv @@
// Shared per-slot countdown and service step, applied to one slot per cycle.
module ptb_slot_unit import ptb_pkg::*; (
   input  logic                is_service,
   input  slot_flags_type      flags,
   input  logic [REM_W-1:0]    remaining,
   input  logic [RELOAD_W-1:0] period,
   input  logic [PERIOD_W-1:0] tick_period,
   output slot_update_type     upd
);

   logic [REM_W-1:0] diff;
   logic             rem_positive;
   logic             diff_expired;

   assign diff         = remaining - {{(REM_W-PERIOD_W){1'b0}}, tick_period};
   assign rem_positive = !remaining[REM_W-1] && (remaining != '0);
   assign diff_expired = diff[REM_W-1] || (diff == '0);

   always_comb begin
      upd.active    = flags.active;
      upd.pending   = flags.pending;
      upd.fire      = 1'b0;
      upd.remaining = remaining;
      if (is_service) begin
         upd.fire = flags.active && flags.pending;
      end else if (flags.active && rem_positive) begin
         if (diff_expired) begin
            upd.pending   = 1'b1;
            upd.remaining = {1'b0, period};
            upd.fire      = flags.immediate;
         end else begin
            upd.remaining = diff;
         end
      end
      // Firing clears the ready flag and retires a one-shot timer.
      if (upd.fire) begin
         upd.pending = 1'b0;
         if (flags.single_fire) begin
            upd.active = 1'b0;
         end
      end
   end

endmodule

@@ src/periodic_timer_bank_core.sv @@
// Top level of the periodic timer bank: command decode, slot sequencer and state.
//
// Usage: a request is taken at a rising edge where start is high and busy is low.
// Program, start, stop and enable requests, tick or service before the bank is
// enabled, and unknown opcodes answer with one result on the next cycle and
// leave busy low, so such requests may follow each other every cycle.
// An enabled tick or service walks every slot through one shared countdown and
// service unit, one slot per cycle. Each timer that fires produces a result
// with status fired in ascending slot order, and a closing result with last
// set follows the walk. Such a request passes through the scan state, one slot
// at a time, and then the close state; busy stays high until the
// closing result is shown.
// Each result is on rsp_data for one cycle, marked by rsp_valid; the receiver
// cannot stall, so results are never held back.
// Synchronous reset clears all timers, flags and the enable bit; no request is
// lost or pending after reset.
module periodic_timer_bank_core import ptb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(NUM_TIMERS - 1);
   localparam logic [SLOT_W:0]   SLOT_LIM  = (SLOT_W+1)'(NUM_TIMERS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CLOSE
   } state_type;

   state_type             state_ff;
   logic [SLOT_W-1:0]     idx_ff;
   logic                  service_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic                  enabled_ff;
   logic [NUM_TIMERS-1:0] active_ff;
   logic [NUM_TIMERS-1:0] pending_ff;
   logic [NUM_TIMERS-1:0] single_ff;
   logic [NUM_TIMERS-1:0] immediate_ff;
   logic [REM_W-1:0]      remaining_ff [NUM_TIMERS];
   logic [RELOAD_W-1:0]   reload_ff [NUM_TIMERS];
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  accept;
   logic                  slot_ok;
   slot_flags_type        cur_flags;
   slot_update_type       upd;

   assign accept  = start && (state_ff == S_IDLE);
   assign slot_ok = {1'b0, req_data.slot} < SLOT_LIM;
   assign busy    = (state_ff != S_IDLE);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cur_flags.active      = active_ff[idx_ff];
   assign cur_flags.pending     = pending_ff[idx_ff];
   assign cur_flags.single_fire = single_ff[idx_ff];
   assign cur_flags.immediate   = immediate_ff[idx_ff];

   ptb_slot_unit u_slot (
      .is_service  (service_ff),
      .flags       (cur_flags),
      .remaining   (remaining_ff[idx_ff]),
      .period      (reload_ff[idx_ff]),
      .tick_period (period_ff),
      .upd         (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         service_ff   <= 1'b0;
         period_ff    <= '0;
         enabled_ff   <= 1'b0;
         active_ff    <= '0;
         pending_ff   <= '0;
         single_ff    <= '0;
         immediate_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            remaining_ff[i] <= '0;
            reload_ff[i]    <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.status     <= ST_OK;
                  rsp_ff.fired_slot <= '0;
                  rsp_ff.last       <= 1'b1;
                  unique case (req_data.opcode)
                     OP_PROGRAM: begin
                        if (!slot_ok) begin
                           rsp_ff.status <= ST_ERR;
                        end else begin
                           remaining_ff[req_data.slot] <= {1'b0, req_data.reload_value};
                           reload_ff[req_data.slot]    <= req_data.reload_value;
                           pending_ff[req_data.slot]   <= 1'b0;
                           single_ff[req_data.slot]    <= req_data.one_shot;
                           immediate_ff[req_data.slot] <= req_data.urgent;
                           active_ff[req_data.slot]    <= 1'b1;
                        end
                     end
                     OP_START: begin
                        if (!slot_ok || active_ff[req_data.slot]) begin
                           rsp_ff.status <= ST_ERR;
                        end else begin
                           active_ff[req_data.slot] <= 1'b1;
                        end
                     end
                     OP_STOP: begin
                        if (!slot_ok || !active_ff[req_data.slot]) begin
                           rsp_ff.status <= ST_ERR;
                        end else begin
                           active_ff[req_data.slot] <= 1'b0;
                        end
                     end
                     OP_ENABLE: begin
                        if (enabled_ff) begin
                           rsp_ff.status <= ST_ERR;
                        end else begin
                           enabled_ff <= 1'b1;
                        end
                     end
                     OP_TICK, OP_SERVICE: begin
                        if (!enabled_ff) begin
                           rsp_ff.status <= ST_OFF;
                        end else begin
                           // The closing result comes after the walk instead.
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_SCAN;
                           idx_ff       <= '0;
                           service_ff   <= (req_data.opcode == OP_SERVICE);
                           period_ff    <= req_data.tick_period;
                        end
                     end
                     default: begin
                        rsp_ff.status <= ST_ERR;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               active_ff[idx_ff]    <= upd.active;
               pending_ff[idx_ff]   <= upd.pending;
               remaining_ff[idx_ff] <= upd.remaining;
               rsp_valid_ff         <= upd.fire;
               rsp_ff.status        <= ST_FIRED;
               rsp_ff.fired_slot    <= idx_ff;
               rsp_ff.last          <= 1'b0;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_CLOSE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_CLOSE: begin
               rsp_valid_ff      <= 1'b1;
               rsp_ff.status     <= ST_OK;
               rsp_ff.fired_slot <= '0;
               rsp_ff.last       <= 1'b1;
               state_ff          <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FIRED) |-> !rsp_data.last)
      else $error("fired result marked as last");

   a_fired_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FIRED) |->
         (rsp_data.fired_slot == $past(idx_ff)) && ($past(state_ff) == S_SCAN))
      else $error("fired result does not match the scanned slot");

   a_short_request_closes: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.opcode != OP_TICK) && (req_data.opcode != OP_SERVICE)
         |=> rsp_valid && rsp_data.last && !busy)
      else $error("short request did not close on the next cycle");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for periodic_timer_bank_core.
module tb;
   import ptb_pkg::*;

   localparam logic [2:0] OP_BAD_6 = 3'd6;
   localparam logic [2:0] OP_BAD_7 = 3'd7;
   localparam int RANDOM_REQUESTS = 95;
   localparam int CYCLE_LIMIT = 200000;

   localparam rsp_type DONE_OK  = '{ST_OK, 4'd0, 1'b1};
   localparam rsp_type DONE_ERR = '{ST_ERR, 4'd0, 1'b1};
   localparam rsp_type DONE_OFF = '{ST_OFF, 4'd0, 1'b1};

   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type answer;
   } vector_row_type;

   // Rows with known set carry their single closing result; the rest are predicted.
   localparam vector_row_type DIRECTED [25] = '{
      '{'{OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hFF}, 1'b1, DONE_OFF},
      '{'{OP_SERVICE, 4'd15, 16'hFFFF, 1'b1, 1'b1, 8'h00}, 1'b1, DONE_OFF},
      '{'{OP_BAD_6, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_ERR},
      '{'{OP_BAD_7, 4'd15, 16'hFFFF, 1'b1, 1'b1, 8'hFF}, 1'b1, DONE_ERR},
      '{'{OP_START, 4'd3, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_STOP, 4'd3, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_STOP, 4'd3, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_ERR},
      '{'{OP_PROGRAM, 4'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_START, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_ERR},
      '{'{OP_ENABLE, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_ENABLE, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_ERR},
      '{'{OP_PROGRAM, 4'd15, 16'h0000, 1'b1, 1'b1, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_PROGRAM, 4'd1, 16'h0001, 1'b1, 1'b1, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_PROGRAM, 4'd2, 16'd255, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_PROGRAM, 4'd4, 16'd300, 1'b0, 1'b1, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hFF}, 1'b0, DONE_OK},
      '{'{OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, DONE_OK},
      '{'{OP_STOP, 4'd2, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_SERVICE, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, DONE_OK},
      '{'{OP_START, 4'd2, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_SERVICE, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, DONE_OK},
      '{'{OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hFF}, 1'b0, DONE_OK},
      '{'{OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0, 8'hFF}, 1'b0, DONE_OK},
      '{'{OP_PROGRAM, 4'd0, 16'h8000, 1'b1, 1'b0, 8'h00}, 1'b1, DONE_OK},
      '{'{OP_SERVICE, 4'd0, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, DONE_OK}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Known answer that travels with the request on the stimulus side.
   logic    answer_known;
   rsp_type answer_rsp;

   // Mirror of the timer bank.
   logic                    t_active [NUM_TIMERS];
   logic signed [REM_W-1:0] t_count [NUM_TIMERS];
   logic [RELOAD_W-1:0]     t_period [NUM_TIMERS];
   logic                    t_pending [NUM_TIMERS];
   logic                    t_single [NUM_TIMERS];
   logic                    t_immediate [NUM_TIMERS];
   logic                    t_enabled;

   rsp_type step_out [$];
   rsp_type due_q [$];

   int cycle_count = 0;
   int fail_count = 0;
   int taken_count = 0;
   int checked_count = 0;
   int fired_count = 0;
   int walk_count = 0;
   int burst_left = 0;

   periodic_timer_bank_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type closing(input status_type st);
      rsp_type r;
      r = '{st, 4'd0, 1'b1};
      return r;
   endfunction

   function automatic void fire_slot(input int i);
      if (t_single[i]) t_active[i] = 1'b0;
      t_pending[i] = 1'b0;
      step_out.push_back('{ST_FIRED, SLOT_W'(i), 1'b0});
      fired_count++;
   endfunction

   // Applies one request to the mirror and leaves its results in step_out.
   function automatic void bank_step(input req_type r);
      logic signed [REM_W-1:0] nxt;
      step_out.delete();
      case (r.opcode)
         OP_PROGRAM: begin
            t_count[r.slot] = $signed({1'b0, r.reload_value});
            t_period[r.slot] = r.reload_value;
            t_pending[r.slot] = 1'b0;
            t_single[r.slot] = r.one_shot;
            t_immediate[r.slot] = r.urgent;
            t_active[r.slot] = 1'b1;
            step_out.push_back(closing(ST_OK));
         end
         OP_START: begin
            if (t_active[r.slot]) begin
               step_out.push_back(closing(ST_ERR));
            end else begin
               t_active[r.slot] = 1'b1;
               step_out.push_back(closing(ST_OK));
            end
         end
         OP_STOP: begin
            if (!t_active[r.slot]) begin
               step_out.push_back(closing(ST_ERR));
            end else begin
               t_active[r.slot] = 1'b0;
               step_out.push_back(closing(ST_OK));
            end
         end
         OP_ENABLE: begin
            step_out.push_back(closing(t_enabled ? ST_ERR : ST_OK));
            t_enabled = 1'b1;
         end
         OP_TICK: begin
            if (!t_enabled) begin
               step_out.push_back(closing(ST_OFF));
            end else begin
               walk_count++;
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  // Only active slots with a positive count take part.
                  if (t_active[i] && !t_count[i][REM_W-1] && t_count[i] != '0) begin
                     nxt = t_count[i] - REM_W'($signed({1'b0, r.tick_period}));
                     if (nxt[REM_W-1] || nxt == '0) begin
                        t_pending[i] = 1'b1;
                        t_count[i] = $signed({1'b0, t_period[i]});
                        if (t_immediate[i]) fire_slot(i);
                     end else begin
                        t_count[i] = nxt;
                     end
                  end
               end
               step_out.push_back(closing(ST_OK));
            end
         end
         OP_SERVICE: begin
            if (!t_enabled) begin
               step_out.push_back(closing(ST_OFF));
            end else begin
               walk_count++;
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (t_active[i] && t_pending[i]) fire_slot(i);
               end
               step_out.push_back(closing(ST_OK));
            end
         end
         default: step_out.push_back(closing(ST_ERR));
      endcase
   endfunction

   // Mostly programs and ticks with short periods so that timers expire often.
   function automatic req_type random_request();
      req_type r;
      int pick;
      r.slot = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      r.reload_value = RELOAD_W'($urandom);
      r.one_shot = 1'($urandom_range(0, 1));
      r.urgent = 1'($urandom_range(0, 1));
      r.tick_period = PERIOD_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.opcode = OP_PROGRAM;
         if ($urandom_range(0, 9) < 7)
            r.reload_value = RELOAD_W'($urandom_range(1, 700));
         else if ($urandom_range(0, 2) == 0)
            r.reload_value = '0;
      end else if (pick < 65) begin
         r.opcode = OP_TICK;
      end else if (pick < 80) begin
         r.opcode = OP_SERVICE;
      end else if (pick < 88) begin
         r.opcode = OP_START;
      end else if (pick < 96) begin
         r.opcode = OP_STOP;
      end else if (pick < 98) begin
         r.opcode = OP_ENABLE;
      end else begin
         r.opcode = ($urandom_range(0, 1) == 0) ? OP_BAD_6 : OP_BAD_7;
      end
      return r;
   endfunction

   task automatic issue(input req_type r, input logic known, input rsp_type answer);
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      answer_known <= known;
      answer_rsp <= answer;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Sender works in bursts; between most bursts start drops for a random gap.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (due_q.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("periodic_timer_bank_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            bank_step(req_data);
            taken_count++;
            if (answer_known) due_q.push_back(answer_rsp);
            else foreach (step_out[k]) due_q.push_back(step_out[k]);
         end
         if (rsp_valid) begin
            if (due_q.size() == 0) begin
               $error("unexpected result: status %0d slot %0d last %0d",
                      rsp_data.status, rsp_data.fired_slot, rsp_data.last);
               fail_count++;
            end else begin
               want = due_q.pop_front();
               checked_count++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.fired_slot !== want.fired_slot) begin
                  $error("fired_slot: expected %0d, got %0d",
                         want.fired_slot, rsp_data.fired_slot);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      answer_known = 1'b0;
      answer_rsp = '0;
      t_enabled = 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         t_active[i] = 1'b0;
         t_count[i] = '0;
         t_period[i] = '0;
         t_pending[i] = 1'b0;
         t_single[i] = 1'b0;
         t_immediate[i] = 1'b0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < $size(DIRECTED); n++) begin
         pace();
         issue(DIRECTED[n].req, DIRECTED[n].known, DIRECTED[n].answer);
      end

      // Let the bank settle completely before the random traffic starts.
      drain();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pace();
         issue(random_request(), 1'b0, DONE_OK);
         if (n % 40 == 39) drain();
      end

      drain();
      repeat (NUM_TIMERS + 4) @(posedge clock);

      $display("%0d requests taken, %0d results checked in %0d cycles.",
               taken_count, checked_count, cycle_count);
      $display("%0d tick or service walks, %0d timer firings predicted.",
               walk_count, fired_count);
      if (fail_count == 0)
         $display("periodic_timer_bank_core: match");
      else
         $display("periodic_timer_bank_core: mismatch");
      $finish;
   end

endmodule
